### hdl/mono_page_framebuffer_text_draw_top_assert.svh
// Assertion macros for the page frame store with text blitter.
`ifndef MONO_PAGE_FRAMEBUFFER_TEXT_DRAW_TOP_ASSERT_SVH
`define MONO_PAGE_FRAMEBUFFER_TEXT_DRAW_TOP_ASSERT_SVH
`ifndef SYNTH
// Checked on every clock edge once reset is released.
`define MPF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Checked on every clock edge, reset included.
`define MPF_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define MPF_ASSERT(label, prop, msg)
`define MPF_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

### hdl/mpf_pkg.sv
// Shared types, constants and the 6x8 font table for the page frame store.
`timescale 1ns / 1ps
package mpf_pkg;

    // Item kinds carried in the input tuser field.
    typedef enum logic [1:0] {
        KIND_PIXEL = 2'd0,
        KIND_GLYPH = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_READ  = 2'd3
    } t_kind;

    // Source of the store write data.
    typedef enum logic [1:0] {
        WSEL_ZERO  = 2'd0,
        WSEL_PIXEL = 2'd1,
        WSEL_GLYPH = 2'd2
    } t_wsel;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic  accept;
        logic  mem_re;
        logic  mem_we;
        t_wsel wsel;
        logic  step;
        logic  out_load;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_kind in_kind;
        logic  in_drop;
        logic  is_pixel;
        logic  glyph_last;
        logic  clear_last;
    } t_dp_sts;

    localparam int          GLYPH_WIDTH = 6;
    localparam int          GLYPH_COUNT = 95;
    localparam logic [7:0]  FIRST_CODE  = 8'h20;
    localparam logic [7:0]  LAST_CODE   = 8'h7E;
    localparam logic [2:0]  GLYPH_LAST_COL = 3'(GLYPH_WIDTH - 1);

    // One glyph per row, leftmost column in the top byte, bit 0 is the top pixel.
    localparam logic [47:0] FONT_ROM [GLYPH_COUNT] = '{
        48'h000000000000, 48'h00005F000000, 48'h000700070000, 48'h147F147F1400,
        48'h242A7F2A1200, 48'h231308646200, 48'h364955225000, 48'h000503000000,
        48'h001C22410000, 48'h0041221C0000, 48'h082A1C2A0800, 48'h08083E080800,
        48'h005030000000, 48'h080808080800, 48'h006060000000, 48'h201008040200,
        48'h3E5149453E00, 48'h00427F400000, 48'h426151494600, 48'h2141454B3100,
        48'h1814127F1000, 48'h274545453900, 48'h3C4A49493000, 48'h017109050300,
        48'h364949493600, 48'h064949291E00, 48'h003636000000, 48'h005636000000,
        48'h000814224100, 48'h141414141400, 48'h412214080000, 48'h020151090600,
        48'h324979413E00, 48'h7E1111117E00, 48'h7F4949493600, 48'h3E4141412200,
        48'h7F4141221C00, 48'h7F4949494100, 48'h7F0909010100, 48'h3E4141513200,
        48'h7F0808087F00, 48'h00417F410000, 48'h2040413F0100, 48'h7F0814224100,
        48'h7F4040404000, 48'h7F0204027F00, 48'h7F0408107F00, 48'h3E4141413E00,
        48'h7F0909090600, 48'h3E4151215E00, 48'h7F0919294600, 48'h464949493100,
        48'h01017F010100, 48'h3F4040403F00, 48'h1F2040201F00, 48'h7F2018207F00,
        48'h631408146300, 48'h030478040300, 48'h615149454300, 48'h007F41410000,
        48'h552A552A5500, 48'h0041417F0000, 48'h040201020400, 48'h404040404000,
        48'h000102040000, 48'h205454547800, 48'h7F4844443800, 48'h384444442000,
        48'h384444487F00, 48'h385454541800, 48'h087E09010200, 48'h18A4A4A47C00,
        48'h7F0804047800, 48'h00447D400000, 48'h4080847D0000, 48'h7F1028440000,
        48'h00417F400000, 48'h7C0418047800, 48'h7C0804047800, 48'h384444443800,
        48'hFC2424241800, 48'h18242418FC00, 48'h7C0804040800, 48'h485454542000,
        48'h043F44402000, 48'h3C4040207C00, 48'h1C2040201C00, 48'h3C4030403C00,
        48'h442810284400, 48'h1CA0A0A07C00, 48'h4464544C4400, 48'h000877000000,
        48'h00007F000000, 48'h007708000000, 48'h100810080000
    };

    // Codes without a glyph fall back to the blank.
    function automatic logic [6:0] glyph_index(input logic [7:0] code);
        logic [7:0] offs;
        offs = code - FIRST_CODE;
        if (code >= FIRST_CODE && code <= LAST_CODE) begin
            return offs[6:0];
        end
        return 7'd0;
    endfunction

endpackage

### hdl/mono_page_framebuffer_text_draw_top.sv
// Top level of the page-organized monochrome frame store with 6x8 text blitter.
//
//  Channel   Direction  Words                     Handshake
//  s_axis    in         draw, blit, clear, read   tvalid/tready
//  m_axis    out        read byte, drop flag      tvalid/tready
//  cfg       in         text margin register      i_cfg_wen, no wait
//
// The single store port sets the sequence of each word: a pixel is a read then a write,
// a glyph one write per column, a clear one write per byte, a read one read; then the
// result register is loaded. Dropped words go straight to loading the result register.
// After reset every byte of the store is swept to zero with s_axis_tready low; margin
// writes are taken meanwhile.
// A word is accepted only while idle; a held result stalls the next one at its end.
`timescale 1ns / 1ps
`include "mono_page_framebuffer_text_draw_top_assert.svh"
module mono_page_framebuffer_text_draw_top
    import mpf_pkg::*;
#(
    parameter int PANEL_COLUMNS = 128,
    parameter int PANEL_PAGES   = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wen,
    input  logic [6:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // x[7:0], y[15:8], color[16], char_code[24:17]
    input  logic [1:0]  s_axis_tuser,  // kind[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // read_data[7:0]
    output logic [0:0]  m_axis_tuser   // dropped[0]
);

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    out_drop;

    mpf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    mpf_datapath #(
        .PANEL_COLUMNS (PANEL_COLUMNS),
        .PANEL_PAGES   (PANEL_PAGES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (s_axis_tdata),
        .i_in_kind   (s_axis_tuser),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_data  (m_axis_tdata),
        .o_out_drop  (out_drop)
    );

    assign m_axis_tuser = out_drop;

    // The controller leaves idle right after taking a word.
    `MPF_ASSERT(a_busy_after_accept, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready, "ready stayed high after an accepted word")
    // A dropped word never returns store data.
    `MPF_ASSERT(a_drop_zero_data, (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == 8'h00), "dropped result carries nonzero data")
    // Reset starts the clearing sweep with both sides quiet.
    `MPF_ASSERT_ALWAYS(a_reset_quiet, !i_rst_n |=> (!s_axis_tready && !m_axis_tvalid), "ready or valid high right after reset")

endmodule

### hdl/mpf_datapath.sv
// Datapath: frame store memory, address and range checks, glyph shifter, result register.
`timescale 1ns / 1ps
module mpf_datapath
    import mpf_pkg::*;
#(
    parameter int PANEL_COLUMNS = 128,
    parameter int PANEL_PAGES   = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wen,
    input  logic [6:0]  i_cfg_wdata,
    input  logic [31:0] i_in_data,
    input  logic [1:0]  i_in_kind,
    input  t_dp_cmd     i_cmd,
    output t_dp_sts     o_sts,
    output logic [7:0]  o_out_data,
    output logic        o_out_drop
);

    localparam int         DEPTH  = PANEL_COLUMNS * PANEL_PAGES;
    localparam int         AW     = $clog2(DEPTH);
    localparam logic [8:0] COLS9  = 9'(PANEL_COLUMNS);
    localparam logic [9:0] COLS10 = 10'(PANEL_COLUMNS);
    localparam logic [8:0] PAGES9 = 9'(PANEL_PAGES);
    localparam logic [8:0] ROWS9  = 9'(PANEL_PAGES * 8);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    // Input word fields.
    logic [7:0] in_x;
    logic [7:0] in_y;
    logic       in_color;
    logic [7:0] in_code;
    t_kind      in_kind;

    assign in_x     = i_in_data[7:0];
    assign in_y     = i_in_data[15:8];
    assign in_color = i_in_data[16];
    assign in_code  = i_in_data[24:17];
    assign in_kind  = t_kind'(i_in_kind);

    // Configuration register.
    logic [6:0] r_margin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_margin <= 7'd0;
        end else if (i_cfg_wen) begin
            r_margin <= i_cfg_wdata;
        end
    end

    // Range checks and start address of the incoming word.
    logic [8:0]    gl_start;
    logic [9:0]    gl_end;
    logic          drop_pix;
    logic          drop_gl;
    logic          drop_rd;
    logic          in_drop;
    logic [7:0]    page_sel;
    logic [8:0]    col_sel;
    logic [16:0]   addr_full;
    logic [AW-1:0] in_addr;

    always_comb begin
        gl_start = {1'b0, in_x} + {2'b00, r_margin};
        gl_end   = {1'b0, gl_start} + 10'(GLYPH_WIDTH);
        drop_pix = ({1'b0, in_x} >= COLS9) || ({1'b0, in_y} >= ROWS9);
        drop_gl  = ({1'b0, in_y} >= PAGES9) || (gl_end > COLS10);
        drop_rd  = ({1'b0, in_x} >= COLS9) || ({1'b0, in_y} >= PAGES9);
        case (in_kind)
            KIND_PIXEL: in_drop = drop_pix;
            KIND_GLYPH: in_drop = drop_gl;
            KIND_READ:  in_drop = drop_rd;
            default:    in_drop = 1'b0;
        endcase
        page_sel  = (in_kind == KIND_PIXEL) ? {3'b000, in_y[7:3]} : in_y;
        col_sel   = (in_kind == KIND_GLYPH) ? gl_start : {1'b0, in_x};
        addr_full = 17'(page_sel) * 17'(PANEL_COLUMNS) + 17'(col_sel);
        in_addr   = (in_kind == KIND_CLEAR) ? '0 : addr_full[AW-1:0];
    end

    // Item registers captured at accept.
    logic [AW-1:0] r_addr;
    logic [2:0]    r_gcnt;
    logic [47:0]   r_glyph;
    logic [2:0]    r_bit;
    logic          r_color;
    logic          r_drop;
    logic          r_is_pixel;
    logic          r_is_read;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
            r_gcnt <= 3'd0;
        end else if (i_cmd.accept) begin
            r_addr <= in_addr;
            r_gcnt <= 3'd0;
        end else if (i_cmd.step) begin
            r_addr <= r_addr + AW'(1);
            r_gcnt <= r_gcnt + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_glyph    <= FONT_ROM[glyph_index(in_code)];
            r_bit      <= in_y[2:0];
            r_color    <= in_color;
            r_drop     <= in_drop;
            r_is_pixel <= (in_kind == KIND_PIXEL);
            r_is_read  <= (in_kind == KIND_READ);
        end else if (i_cmd.step) begin
            r_glyph <= {r_glyph[39:0], 8'h00};
        end
    end

    // Frame store with one write and one registered read.
    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;
    logic [7:0] wdata;
    logic [7:0] pix_mask;

    always_comb begin
        pix_mask = 8'h01 << r_bit;
        case (i_cmd.wsel)
            WSEL_PIXEL: wdata = r_color ? (r_rdata | pix_mask) : (r_rdata & ~pix_mask);
            WSEL_GLYPH: wdata = r_glyph[47:40];
            default:    wdata = 8'h00;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_we) begin
            r_mem[r_addr] <= wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_re) begin
            r_rdata <= r_mem[r_addr];
        end
    end

    // Result register.
    logic [7:0] r_out_data;
    logic       r_out_drop;

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= (r_is_read && !r_drop) ? r_rdata : 8'h00;
            r_out_drop <= r_drop;
        end
    end

    assign o_out_data = r_out_data;
    assign o_out_drop = r_out_drop;

    // Status toward the controller.
    always_comb begin
        o_sts.in_kind    = in_kind;
        o_sts.in_drop    = in_drop;
        o_sts.is_pixel   = r_is_pixel;
        o_sts.glyph_last = (r_gcnt == GLYPH_LAST_COL);
        o_sts.clear_last = (r_addr == LAST_ADDR);
    end

endmodule

### hdl/mpf_ctrl.sv
// Controller: sequences clearing sweeps, pixel updates, glyph writes and reads.
`timescale 1ns / 1ps
module mpf_ctrl
    import mpf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [5:0] {
        ST_CLEAR  = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_READ   = 6'b000100,
        ST_MODIFY = 6'b001000,
        ST_GLYPH  = 6'b010000,
        ST_RESULT = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_clr_item;
    logic   n_clr_item;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   accept;
    logic   out_free;

    assign accept   = (r_state == ST_IDLE) && i_in_valid;
    assign out_free = !r_out_valid || i_out_ready;

    // Next state and datapath commands.
    always_comb begin
        n_state        = r_state;
        n_clr_item     = r_clr_item;
        o_cmd.accept   = 1'b0;
        o_cmd.mem_re   = 1'b0;
        o_cmd.mem_we   = 1'b0;
        o_cmd.wsel     = WSEL_ZERO;
        o_cmd.step     = 1'b0;
        o_cmd.out_load = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.mem_we = 1'b1;
                o_cmd.step   = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = r_clr_item ? ST_RESULT : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    o_cmd.accept = 1'b1;
                    case (i_sts.in_kind)
                        KIND_CLEAR: begin
                            n_state    = ST_CLEAR;
                            n_clr_item = 1'b1;
                        end
                        KIND_GLYPH: n_state = i_sts.in_drop ? ST_RESULT : ST_GLYPH;
                        default:    n_state = i_sts.in_drop ? ST_RESULT : ST_READ;
                    endcase
                end
            end
            ST_READ: begin
                o_cmd.mem_re = 1'b1;
                n_state      = i_sts.is_pixel ? ST_MODIFY : ST_RESULT;
            end
            ST_MODIFY: begin
                o_cmd.mem_we = 1'b1;
                o_cmd.wsel   = WSEL_PIXEL;
                n_state      = ST_RESULT;
            end
            ST_GLYPH: begin
                o_cmd.mem_we = 1'b1;
                o_cmd.wsel   = WSEL_GLYPH;
                o_cmd.step   = 1'b1;
                if (i_sts.glyph_last) begin
                    n_state = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_clr_item     = 1'b0;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Output word valid flag.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_item  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_item  <= n_clr_item;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

### bench/tb_top.sv
// Self-checking bench for the page frame store with 6x8 text blitter.
`timescale 1ns / 1ps
module tb_top;
    import mpf_pkg::*;

    localparam int COLUMNS      = 128;
    localparam int PAGES        = 8;
    localparam int ROWS         = PAGES * 8;
    localparam int STORE_BYTES  = COLUMNS * PAGES;
    localparam int PHASES       = 7;
    localparam int PHASE_WORDS  = 150;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int PRINT_LIMIT  = 50;

    // One draw command as the sender sees it.
    typedef struct packed {
        t_kind      kind;
        logic [7:0] x;
        logic [7:0] y;
        logic       color;
        logic [7:0] code;
    } t_draw_word;

    // One result word: the byte read back and the drop flag.
    typedef struct packed {
        logic [7:0] data;
        logic       drop;
    } t_readback;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_wen     = 1'b0;
    logic [6:0]  i_cfg_wdata   = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;  // x[7:0], y[15:8], color[16], char_code[24:17]
    logic [1:0]  s_axis_tuser  = '0;  // kind[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;        // read_data[7:0]
    logic [0:0]  m_axis_tuser;        // dropped[0]

    // Shadow copy of the frame store, the margin register and the results still due.
    class frame_tracker;
        logic [7:0] shadow_frame [STORE_BYTES];
        logic [6:0] margin;
        t_readback  due_results [$];
        int         mismatches;

        function new();
            foreach (shadow_frame[i]) shadow_frame[i] = 8'h00;
            margin     = 7'd0;
            mismatches = 0;
        endfunction

        function void set_margin(logic [6:0] value);
            margin = value;
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        task report(string msg);
            if (mismatches < PRINT_LIMIT) begin
                $display("%0t mismatch: %s", $time, msg);
            end
            mismatches++;
        endtask

        // Apply one accepted word to the shadow store and queue its result.
        function void note_word(t_draw_word w);
            t_readback   r;
            int          start;
            int          glyph;
            logic [47:0] columns;
            r.data = 8'h00;
            r.drop = 1'b0;
            case (w.kind)
                KIND_PIXEL: begin
                    if (w.x < COLUMNS && w.y < ROWS) begin
                        shadow_frame[(w.y >> 3) * COLUMNS + w.x][w.y[2:0]] = w.color;
                    end else begin
                        r.drop = 1'b1;
                    end
                end
                KIND_GLYPH: begin
                    start = int'(w.x) + int'(margin);
                    if (w.y >= PAGES || start + GLYPH_WIDTH > COLUMNS) begin
                        r.drop = 1'b1;
                    end else begin
                        // Codes outside the printable range draw the blank glyph.
                        glyph = (w.code >= FIRST_CODE && w.code <= LAST_CODE) ?
                                int'(w.code - FIRST_CODE) : 0;
                        columns = FONT_ROM[glyph];
                        for (int i = 0; i < GLYPH_WIDTH; i++) begin
                            shadow_frame[w.y * COLUMNS + start + i] = columns[47 - 8 * i -: 8];
                        end
                    end
                end
                KIND_CLEAR: begin
                    foreach (shadow_frame[i]) shadow_frame[i] = 8'h00;
                end
                default: begin
                    if (w.x < COLUMNS && w.y < PAGES) begin
                        r.data = shadow_frame[w.y * COLUMNS + w.x];
                    end else begin
                        r.drop = 1'b1;
                    end
                end
            endcase
            due_results.push_back(r);
        endfunction

        // Compare one result word with the oldest one still due.
        task check_result(logic [7:0] data, logic drop);
            t_readback r;
            if (due_results.size() == 0) begin
                report($sformatf("unexpected result data=%02h dropped=%0b", data, drop));
            end else begin
                r = due_results.pop_front();
                if (data !== r.data) begin
                    report($sformatf("read_data %02h, wanted %02h", data, r.data));
                end
                if (drop !== r.drop) begin
                    report($sformatf("dropped %0b, wanted %0b", drop, r.drop));
                end
            end
        endtask
    endclass

    frame_tracker tracker = new();

    int   cur_margin   = 0;
    int   hot_col      = 0;
    int   hot_page     = 0;
    bit   tx_idle_on   = 1'b1;
    bit   rx_idle_on   = 1'b1;
    bit   hold_request = 1'b0;
    int   cycles       = 0;

    mono_page_framebuffer_text_draw_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 12 ns clock.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Every result word is checked as it is taken.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            tracker.check_result(m_axis_tdata, m_axis_tuser[0]);
        end
    end

    // Stall lengths: mostly short, a few long.
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) begin
            return $urandom_range(1, 3);
        end else if (r < 95) begin
            return $urandom_range(4, 8);
        end
        return $urandom_range(20, 60);
    endfunction

    // Result side: random stalls, plus one long hold-off when asked for.
    initial begin : result_side
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left   = HOLD_CYCLES;
            end else if (stall_left == 0 && rx_idle_on && $urandom_range(0, 99) < 20) begin
                stall_left = idle_length();
            end
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    function automatic t_draw_word make_word(t_kind kind, int x, int y, int color, int code);
        t_draw_word w;
        w.kind  = kind;
        w.x     = 8'(x);
        w.y     = 8'(y);
        w.color = 1'(color);
        w.code  = 8'(code);
        return w;
    endfunction

    // Random command, biased toward the area drawn last so reads see real content.
    function automatic t_draw_word next_word();
        t_draw_word w;
        int         pick;
        int         roll;
        w.kind  = KIND_READ;
        w.x     = 8'($urandom_range(0, 255));
        w.y     = 8'($urandom_range(0, 255));
        w.color = 1'($urandom_range(0, 1));
        w.code  = 8'($urandom_range(0, 255));
        pick    = $urandom_range(0, 999);
        roll    = $urandom_range(0, 99);
        if (pick < 350) begin
            w.kind = KIND_PIXEL;
            if (roll < 45) begin
                w.x = 8'((hot_col + $urandom_range(0, 7)) % COLUMNS);
                w.y = 8'(hot_page * 8 + $urandom_range(0, 7));
            end else if (roll < 88) begin
                w.x = 8'($urandom_range(0, COLUMNS - 1));
                w.y = 8'($urandom_range(0, ROWS - 1));
            end
            if (roll < 88) begin
                hot_col  = w.x;
                hot_page = w.y >> 3;
            end
        end else if (pick < 600) begin
            w.kind = KIND_GLYPH;
            if (roll < 85) begin
                w.y = 8'($urandom_range(0, PAGES - 1));
                if (cur_margin + GLYPH_WIDTH <= COLUMNS) begin
                    w.x = 8'($urandom_range(0, COLUMNS - GLYPH_WIDTH - cur_margin));
                end else begin
                    w.x = 8'($urandom_range(0, 7));
                end
                hot_col  = (w.x + cur_margin) % COLUMNS;
                hot_page = w.y;
            end
            if ($urandom_range(0, 99) < 70) begin
                w.code = 8'($urandom_range(FIRST_CODE, LAST_CODE));
            end
        end else if (pick < 992) begin
            if (roll < 70) begin
                w.x = 8'((hot_col + $urandom_range(0, 7)) % COLUMNS);
                w.y = 8'(hot_page);
            end else if (roll < 85) begin
                w.x = 8'($urandom_range(0, COLUMNS - 1));
                w.y = 8'($urandom_range(0, PAGES - 1));
            end
        end else begin
            w.kind = KIND_CLEAR;
        end
        return w;
    endfunction

    // Offer one word and hold it until it is taken; valid stays high afterwards.
    task automatic send_word(input t_draw_word w);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, w.code, w.color, w.y, w.x};
        s_axis_tuser  <= w.kind;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        tracker.note_word(w);
    endtask

    task automatic pause_sender(input int gap);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_results_done();
        while (tracker.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_margin(input int value);
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= 7'(value);
        @(posedge i_clk);
        i_cfg_wen   <= 1'b0;
        tracker.set_margin(7'(value));
        cur_margin = value;
    endtask

    // Main sequence: reset, directed words, then random phases at several margins.
    initial begin : stimulus
        t_draw_word directed [$];
        int         phase_margin [PHASES];
        int         value;
        phase_margin = '{127, 122, 0, 1, -1, 64, -1};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_margin(0);

        // Corners, overwrites, blank fallback, edge fits and every drop rule.
        directed.push_back(make_word(KIND_READ,    0,   0, 0, 8'h00));
        directed.push_back(make_word(KIND_PIXEL,   0,   0, 1, 8'hFF));
        directed.push_back(make_word(KIND_PIXEL, 127,  63, 1, 8'h00));
        directed.push_back(make_word(KIND_READ,    0,   0, 1, 8'h00));
        directed.push_back(make_word(KIND_READ,  127,   7, 0, 8'h00));
        directed.push_back(make_word(KIND_PIXEL, 127,  63, 0, 8'h41));
        directed.push_back(make_word(KIND_READ,  127,   7, 0, 8'h00));
        directed.push_back(make_word(KIND_PIXEL, 128,   0, 1, 8'h00));
        directed.push_back(make_word(KIND_PIXEL,   0,  64, 1, 8'h00));
        directed.push_back(make_word(KIND_PIXEL, 255, 255, 1, 8'hFF));
        directed.push_back(make_word(KIND_GLYPH,   0,   0, 1, 8'h41));
        directed.push_back(make_word(KIND_READ,    2,   0, 0, 8'h00));
        directed.push_back(make_word(KIND_GLYPH, 122,   7, 0, 8'h1F));
        directed.push_back(make_word(KIND_READ,  122,   7, 0, 8'h00));
        directed.push_back(make_word(KIND_GLYPH,  10,   1, 0, 8'h7F));
        directed.push_back(make_word(KIND_GLYPH,  20,   2, 1, 8'h7E));
        directed.push_back(make_word(KIND_GLYPH,  30,   3, 0, 8'h20));
        directed.push_back(make_word(KIND_GLYPH, 123,   0, 0, 8'h41));
        directed.push_back(make_word(KIND_GLYPH,   0,   8, 0, 8'h41));
        directed.push_back(make_word(KIND_GLYPH, 255, 255, 1, 8'hFF));
        directed.push_back(make_word(KIND_READ,  128,   0, 0, 8'h00));
        directed.push_back(make_word(KIND_READ,    0,   8, 0, 8'h00));
        directed.push_back(make_word(KIND_READ,  255, 255, 1, 8'hFF));
        directed.push_back(make_word(KIND_CLEAR,  77,  99, 1, 8'h55));
        directed.push_back(make_word(KIND_READ,    2,   0, 0, 8'h00));
        foreach (directed[i]) begin
            send_word(directed[i]);
        end
        s_axis_tvalid <= 1'b0;
        wait_results_done();

        for (int phase = 0; phase < PHASES; phase++) begin
            value = (phase_margin[phase] < 0) ? $urandom_range(2, 126) : phase_margin[phase];
            write_margin(value);
            // One phase runs with no idling, another stalls the result side for a long time.
            tx_idle_on = (phase != 3) && (phase != 1);
            rx_idle_on = (phase != 3);
            if (phase == 1) begin
                hold_request = 1'b1;
            end
            for (int n = 0; n < PHASE_WORDS; n++) begin
                send_word(next_word());
                if (tx_idle_on && $urandom_range(0, 99) >= 40) begin
                    pause_sender(idle_length());
                end
            end
            s_axis_tvalid <= 1'b0;
            wait_results_done();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.pending() != 0) begin
            tracker.report($sformatf("%0d results never arrived", tracker.pending()));
        end
        if (tracker.mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
